### hdl/assert_macros.svh
// assertion macros used by gradient_noise_eval_top
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hdl/gne_pkg.sv
// constants, codes and types of the gradient noise evaluator
// used by every module of the block but gne_ram
`default_nettype none
package gne_pkg;
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW = 8;
	localparam int FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int GRAD_W = 16;
	localparam int OFS_W = FRAC_BITS + 1;
	localparam int FADE_W = FRAC_BITS + 1;
	localparam int INNER_W = 28;
	localparam int DOT_SHIFT = 8;
	localparam int OUT_W = 17;
	localparam int CORNER_W = 3;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] MAX_CORNERS = 4'd8;

	localparam logic FUNC_EVAL = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	localparam logic [1:0] CFG_TABLE_SIZE = 2'd0;
	localparam logic [1:0] CFG_DIMENSIONS = 2'd1;

	localparam logic [1:0] DIM_1D = 2'd1;
	localparam logic [1:0] DIM_2D = 2'd2;
	localparam logic [1:0] DIM_3D = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_GRAD,
		ST_LMUL,
		ST_LADD,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

### hdl/gne_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module gne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/gne_fade.sv
// two stage fade curve s = t*t*(3-2t) in fixed point
// depends on gne_pkg
`default_nettype none
module gne_fade import gne_pkg::*; (
	input  wire logic                 clk,
	input  wire logic [FRAC_BITS-1:0] t,
	output logic      [FADE_W-1:0]    s
);
	localparam logic [FRAC_BITS+1:0] THREE = (FRAC_BITS+2)'(3 << FRAC_BITS);

	logic [2*FRAC_BITS-1:0] sq;
	logic [FRAC_BITS-1:0]   t2_s1;
	logic [FRAC_BITS-1:0]   t_s1;
	logic [FRAC_BITS+1:0]   k;
	logic [2*FRAC_BITS+1:0] prod;

	assign sq = t * t;
	assign k = THREE - {1'b0, t_s1, 1'b0};
	assign prod = t2_s1 * k;

	always_ff @(posedge clk) begin
		t2_s1 <= sq[2*FRAC_BITS-1:FRAC_BITS];
		t_s1 <= t;
		s <= prod[FRAC_BITS+FADE_W-1:FRAC_BITS];
	end
endmodule
`default_nettype wire

### hdl/gne_dot.sv
// corner dot product: three registered products, then sum and scale
// depends on gne_pkg
`default_nettype none
module gne_dot import gne_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       vld,
	input  wire logic        [CORNER_W-1:0] corner,
	input  wire logic signed [OFS_W-1:0]    rx,
	input  wire logic signed [OFS_W-1:0]    ry,
	input  wire logic signed [OFS_W-1:0]    rz,
	input  wire logic signed [GRAD_W-1:0]   gx,
	input  wire logic signed [GRAD_W-1:0]   gy,
	input  wire logic signed [GRAD_W-1:0]   gz,
	output logic                            vld_s2,
	output logic             [CORNER_W-1:0] corner_s2,
	output logic signed      [INNER_W-1:0]  dot
);
	localparam int PW = OFS_W + GRAD_W;
	localparam int SW = PW + 2;

	logic signed [PW-1:0] px_s2, py_s2, pz_s2;
	logic signed [SW-1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		corner_s2 <= corner;
		px_s2 <= rx * gx;
		py_s2 <= ry * gy;
		pz_s2 <= rz * gz;
	end

	assign sum = SW'(px_s2) + SW'(py_s2) + SW'(pz_s2);
	// floor to 23 fraction bits
	assign dot = INNER_W'($signed(sum[SW-1:DOT_SHIFT]));
endmodule
`default_nettype wire

### hdl/gradient_noise_eval_top.sv
// gradient noise evaluator top: tables in rams, hash and gradient sequencer,
// dot unit and lerp queue; depends on gne_pkg, gne_ram, gne_fade, gne_dot, assert_macros.svh
//
// channel   direction  handshake                      payload
// item      in         start & !busy                  func x y z entry_index perm_value grads
// result    out        done, one cycle, no backpress  noise_value
// config    in         cfg_valid & cfg_ready          cfg_index cfg_data
//
// a load beat writes all four tables at once and busy stays low.
// an evaluate beat keeps busy high through the hash, gradient, lerp and output states;
// the next beat can be taken in the first cycle with busy low. the evaluation time is
// set by the single read port of the permutation and gradient memories (one lookup
// a cycle) and the shared lerp multiplier, with a multiply and an add state per lerp.
// done pulses in the first cycle with busy low; tables are undefined after reset.
`default_nettype none
module gradient_noise_eval_top import gne_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      func,
	input  wire logic signed [COORD_W-1:0] x,
	input  wire logic signed [COORD_W-1:0] y,
	input  wire logic signed [COORD_W-1:0] z,
	input  wire logic        [TBL_AW-1:0]  entry_index,
	input  wire logic        [TBL_AW-1:0]  perm_value,
	input  wire logic signed [GRAD_W-1:0]  grad1,
	input  wire logic signed [GRAD_W-1:0]  grad2_x,
	input  wire logic signed [GRAD_W-1:0]  grad2_y,
	input  wire logic signed [GRAD_W-1:0]  grad3_x,
	input  wire logic signed [GRAD_W-1:0]  grad3_y,
	input  wire logic signed [GRAD_W-1:0]  grad3_z,
	output logic                           done,
	output logic signed      [OUT_W-1:0]   noise_value,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic        [1:0]         cfg_index,
	input  wire logic        [8:0]         cfg_data
);
`include "assert_macros.svh"

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [8:0] table_size_q;
	logic [1:0] dims_q;
	logic [8:0] tsm1;
	logic [TBL_AW-1:0] mask;
	logic [1:0] dsel;
	logic eval_acc, load_acc;

	logic [1:0] dim_q;
	logic [TBL_AW-1:0] cx0_q, cx1_q, cy0_q, cy1_q, cz0_q, cz1_q;
	logic [TBL_AW-1:0] cx0, cy0, cz0;
	logic [FRAC_BITS-1:0] tx_q, ty_q, tz_q;
	logic [FADE_W-1:0] sx, sy, sz;

	logic [TBL_AW-1:0] i_q, j_q;
	logic [TBL_AW-1:0] h_q [4];
	logic [1:0] hidx;

	logic [TBL_AW-1:0] perm_raddr, grad_raddr, perm_rdata;
	logic [GRAD_W-1:0] g1_rdata;
	logic [2*GRAD_W-1:0] g2_rdata;
	logic [3*GRAD_W-1:0] g3_rdata;

	logic [CNT_W-1:0] ncorn;
	logic issue;
	logic [CORNER_W-1:0] corner;
	logic [TBL_AW-1:0] hsel, zoff;
	logic v_s1;
	logic [CORNER_W-1:0] corner_s1;
	logic signed [OFS_W-1:0] rx, ry, rz;
	logic signed [GRAD_W-1:0] gx, gy, gz;
	logic dot_vld;
	logic [CORNER_W-1:0] dot_corner;
	logic signed [INNER_W-1:0] dot;

	logic signed [INNER_W-1:0] q_q [8];
	logic [CNT_W-1:0] qcnt_q;
	logic [CORNER_W-1:0] lerp_k_q;
	logic [CNT_W-1:0] half, tquart, lk;
	logic [FADE_W-1:0] s_sel;
	logic signed [INNER_W:0] diff;
	logic signed [INNER_W+FADE_W+1:0] lprod_q;
	logic signed [INNER_W-1:0] la_q;
	logic signed [INNER_W-1:0] lerp_res;
	logic signed [INNER_W-DOT_SHIFT-1:0] fv;

	assign cfg_ready = 1'b1;
	assign tsm1 = table_size_q - 9'd1;
	assign mask = tsm1[TBL_AW-1:0];
	assign dsel = (dims_q == 2'd0) ? DIM_1D : dims_q;
	assign eval_acc = start && !busy && (func == FUNC_EVAL);
	assign load_acc = start && !busy && (func == FUNC_LOAD);
	assign cx0 = x[FRAC_BITS+TBL_AW-1:FRAC_BITS] & mask;
	assign cy0 = y[FRAC_BITS+TBL_AW-1:FRAC_BITS] & mask;
	assign cz0 = z[FRAC_BITS+TBL_AW-1:FRAC_BITS] & mask;
	assign ncorn = CNT_W'(1) << dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= 9'd256;
			dims_q <= DIM_3D;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_TABLE_SIZE) begin
				table_size_q <= cfg_data;
			end else if (cfg_index == CFG_DIMENSIONS) begin
				dims_q <= cfg_data[1:0];
			end
		end
	end

	// point capture
	always_ff @(posedge clk) begin
		if (eval_acc) begin
			dim_q <= dsel;
			cx0_q <= cx0;
			cx1_q <= (cx0 + 8'd1) & mask;
			cy0_q <= cy0;
			cy1_q <= (cy0 + 8'd1) & mask;
			cz0_q <= cz0;
			cz1_q <= (cz0 + 8'd1) & mask;
			tx_q <= x[FRAC_BITS-1:0];
			ty_q <= y[FRAC_BITS-1:0];
			tz_q <= z[FRAC_BITS-1:0];
		end
	end

	gne_fade u_fade_x (.clk(clk), .t(tx_q), .s(sx));
	gne_fade u_fade_y (.clk(clk), .t(ty_q), .s(sy));
	gne_fade u_fade_z (.clk(clk), .t(tz_q), .s(sz));

	gne_ram #(.WIDTH(TBL_AW), .DEPTH(TBL_DEPTH)) u_perm (
		.clk(clk), .we(load_acc), .waddr(entry_index), .wdata(perm_value),
		.raddr(perm_raddr), .rdata(perm_rdata)
	);
	gne_ram #(.WIDTH(GRAD_W), .DEPTH(TBL_DEPTH)) u_grad1 (
		.clk(clk), .we(load_acc), .waddr(entry_index), .wdata(grad1),
		.raddr(grad_raddr), .rdata(g1_rdata)
	);
	gne_ram #(.WIDTH(2*GRAD_W), .DEPTH(TBL_DEPTH)) u_grad2 (
		.clk(clk), .we(load_acc), .waddr(entry_index), .wdata({grad2_y, grad2_x}),
		.raddr(grad_raddr), .rdata(g2_rdata)
	);
	gne_ram #(.WIDTH(3*GRAD_W), .DEPTH(TBL_DEPTH)) u_grad3 (
		.clk(clk), .we(load_acc), .waddr(entry_index),
		.wdata({grad3_z, grad3_y, grad3_x}),
		.raddr(grad_raddr), .rdata(g3_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (eval_acc) state_d = ST_HASH;
			ST_HASH: begin
				if ((dim_q == DIM_1D && cnt_q == 4'd2) || cnt_q == 4'd6) state_d = ST_GRAD;
			end
			ST_GRAD: if (cnt_q == ncorn + 4'd1) state_d = ST_LMUL;
			ST_LMUL: state_d = ST_LADD;
			ST_LADD: state_d = (qcnt_q == '0) ? ST_OUT : ST_LMUL;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy = (state_q != ST_IDLE);
		issue = (state_q == ST_GRAD) && (cnt_q < ncorn);
		corner = cnt_q[CORNER_W-1:0];
		unique case (cnt_q)
			4'd0:    perm_raddr = cx0_q;
			4'd1:    perm_raddr = cx1_q;
			4'd2:    perm_raddr = (i_q + cy0_q) & mask;
			4'd3:    perm_raddr = (j_q + cy0_q) & mask;
			4'd4:    perm_raddr = (i_q + cy1_q) & mask;
			default: perm_raddr = (j_q + cy1_q) & mask;
		endcase
		hsel = (dim_q == DIM_1D) ? (corner[0] ? j_q : i_q) : h_q[corner[1:0]];
		zoff = (dim_q == DIM_3D) ? (corner[2] ? cz1_q : cz0_q) : '0;
		grad_raddr = (hsel + zoff) & mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			qcnt_q <= '0;
			lerp_k_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + 4'd1;
			v_s1 <= issue;
			done <= (state_q == ST_OUT);
			if (eval_acc) begin
				lerp_k_q <= '0;
			end else if (state_q == ST_LADD) begin
				lerp_k_q <= lerp_k_q + 3'd1;
			end
			if (state_q == ST_GRAD && state_d == ST_LMUL) begin
				qcnt_q <= ncorn;
			end else if (state_q == ST_LMUL) begin
				qcnt_q <= qcnt_q - 4'd2;
			end else if (state_q == ST_LADD) begin
				qcnt_q <= qcnt_q + 4'd1;
			end
		end
	end

	// hash capture, one permutation beat a cycle
	assign hidx = 2'(cnt_q - 4'd3);
	always_ff @(posedge clk) begin
		if (state_q == ST_HASH) begin
			if (cnt_q == 4'd1) i_q <= perm_rdata;
			if (cnt_q == 4'd2) j_q <= perm_rdata;
			if (cnt_q >= 4'd3) h_q[hidx] <= perm_rdata;
		end
		corner_s1 <= corner;
	end

	// corner offsets: r1 = r0 - 1 is the fraction with the sign bit set
	always_comb begin
		rx = $signed({corner_s1[0], tx_q});
		ry = (dim_q == DIM_1D) ? '0 : $signed({corner_s1[1], ty_q});
		rz = (dim_q == DIM_3D) ? $signed({corner_s1[2], tz_q}) : '0;
		unique case (dim_q)
			DIM_1D: begin
				gx = $signed(g1_rdata);
				gy = '0;
				gz = '0;
			end
			DIM_2D: begin
				gx = $signed(g2_rdata[GRAD_W-1:0]);
				gy = $signed(g2_rdata[2*GRAD_W-1:GRAD_W]);
				gz = '0;
			end
			default: begin
				gx = $signed(g3_rdata[GRAD_W-1:0]);
				gy = $signed(g3_rdata[2*GRAD_W-1:GRAD_W]);
				gz = $signed(g3_rdata[3*GRAD_W-1:2*GRAD_W]);
			end
		endcase
	end

	gne_dot u_dot (
		.clk(clk), .arst_n(arst_n), .vld(v_s1), .corner(corner_s1),
		.rx(rx), .ry(ry), .rz(rz), .gx(gx), .gy(gy), .gz(gz),
		.vld_s2(dot_vld), .corner_s2(dot_corner), .dot(dot)
	);

	// lerp queue: pop two from the head, push the blend at the tail
	always_comb begin
		half = ncorn >> 1;
		tquart = half + (ncorn >> 2);
		lk = {1'b0, lerp_k_q};
		if (lk < half) begin
			s_sel = sx;
		end else if (lk < tquart) begin
			s_sel = sy;
		end else begin
			s_sel = sz;
		end
		diff = (INNER_W+1)'(q_q[1]) - (INNER_W+1)'(q_q[0]);
		lerp_res = la_q + lprod_q[INNER_W+FRAC_BITS-1:FRAC_BITS];
		fv = q_q[0][INNER_W-1:DOT_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (dot_vld) begin
			q_q[dot_corner] <= dot;
		end else if (state_q == ST_LMUL) begin
			for (int k = 0; k < 6; k++) begin
				q_q[k] <= q_q[k+2];
			end
		end else if (state_q == ST_LADD) begin
			q_q[qcnt_q[CORNER_W-1:0]] <= lerp_res;
		end
		if (state_q == ST_LMUL) begin
			lprod_q <= $signed({1'b0, s_sel}) * diff;
			la_q <= q_q[0];
		end
		if (state_q == ST_OUT) begin
			if (fv[INNER_W-DOT_SHIFT-1:OUT_W-1] == '0
			    || fv[INNER_W-DOT_SHIFT-1:OUT_W-1] == '1) begin
				noise_value <= fv[OUT_W-1:0];
			end else if (fv[INNER_W-DOT_SHIFT-1]) begin
				noise_value <= {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				noise_value <= {1'b0, {(OUT_W-1){1'b1}}};
			end
		end
	end

	`ASSERT_IMPL(a_done_after_out, clk, arst_n, done, $past(state_q == ST_OUT), "done without finishing")
	`ASSERT_NEXT(a_eval_busy, clk, arst_n, eval_acc, busy, "evaluate beat did not start work")
	`ASSERT_NEXT(a_load_idle, clk, arst_n, load_acc, !busy && !done, "load beat caused work")
	`ASSERT_CLK(a_qcnt, clk, arst_n, qcnt_q <= MAX_CORNERS, "lerp queue overflow")
endmodule
`default_nettype wire
